// ===== hdl/hssc_pkg.sv =====
package hssc_pkg;

	// field widths
	localparam int COEF_W = 16;
	localparam int WORD_W = 2 * COEF_W;
	localparam int PROD_W = 2 * COEF_W;
	localparam int TERM_W = PROD_W + 2;
	localparam int SUM_W  = 40;
	localparam int MODE_W = 6;
	localparam int CFG_W  = 7;
	localparam int CUT_W  = 6;

	// register indexes on the configuration port
	localparam logic REG_MODE_COUNT  = 1'b0;
	localparam logic REG_CUTOFF_MODE = 1'b1;

	// reset values of the registers
	localparam logic [CFG_W-1:0] MODE_COUNT_RST  = 7'd64;
	localparam logic [CUT_W-1:0] CUTOFF_MODE_RST = 6'd0;

	// commands from the sequencer to one coefficient chain
	typedef struct packed {
		logic wr;
		logic init;
		logic seek_up;
		logic seek_down;
		logic step;
		logic step_pos;
	} hssc_chain_cmd_t;

	// control that travels with each term through the mac pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic zero;
		logic end_run;
	} hssc_term_ctl_t;

endpackage

// ===== hdl/hssc_cell.sv =====
module hssc_cell import hssc_pkg::*; (
	input  logic              clk,
	input  logic [WORD_W-1:0] from_up,
	input  logic [WORD_W-1:0] from_dn,
	input  logic [WORD_W-1:0] din,
	input  logic              we,
	input  logic              sh_up,
	input  logic              sh_dn,
	output logic [WORD_W-1:0] q
);

	logic [WORD_W-1:0] word_q;

	// one coefficient word: load, or take a neighbour's word
	always_ff @(posedge clk) begin
		if (we) begin
			word_q <= din;
		end else if (sh_up) begin
			word_q <= from_up;
		end else if (sh_dn) begin
			word_q <= from_dn;
		end
	end

	assign q = word_q;

endmodule

// ===== hdl/hssc_chain.sv =====
module hssc_chain import hssc_pkg::*; #(
	parameter int MAX_MODES = 64,
	localparam int IW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1,
	localparam int SW = IW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hssc_chain_cmd_t      cmd,
	input  logic [IW-1:0]        wr_idx,
	input  logic [WORD_W-1:0]    wr_data,
	input  logic signed [SW-1:0] init_s,
	output logic [WORD_W-1:0]    tap,
	output logic                 tap_conj,
	output logic signed [SW-1:0] s_idx,
	output logic [IW-1:0]        pos
);

	logic [WORD_W-1:0]    cell_q [MAX_MODES];
	logic signed [SW-1:0] s_q;
	logic [IW-1:0]        pos_q;
	logic                 step_up;
	logic                 mv_up;
	logic                 mv_dn;

	// a step of the signed index moves away from zero or towards it
	always_comb begin
		if (cmd.step_pos) begin
			step_up = !s_q[SW-1];
		end else begin
			step_up = s_q[SW-1] || (s_q == '0);
		end
		mv_up = cmd.seek_up || (cmd.step && step_up);
		mv_dn = cmd.seek_down || (cmd.step && !step_up);
	end

	// ring of cells, cell 0 is the tap
	for (genvar i = 0; i < MAX_MODES; i++) begin : g_cell
		localparam int UP = (i + 1) % MAX_MODES;
		localparam int DN = (i + MAX_MODES - 1) % MAX_MODES;
		hssc_cell u_cell (
			.clk     (clk),
			.from_up (cell_q[UP]),
			.from_dn (cell_q[DN]),
			.din     (wr_data),
			.we      (cmd.wr && (wr_idx == IW'(i))),
			.sh_up   (mv_up),
			.sh_dn   (mv_dn),
			.q       (cell_q[i])
		);
	end

	// ring offset and signed mode index seen at the tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			s_q   <= '0;
		end else begin
			if (mv_up) begin
				pos_q <= pos_q + 1'b1;
			end else if (mv_dn) begin
				pos_q <= pos_q - 1'b1;
			end
			if (cmd.init) begin
				s_q <= init_s;
			end else if (cmd.step) begin
				s_q <= cmd.step_pos ? s_q + SW'(1) : s_q - SW'(1);
			end
		end
	end

	assign tap      = cell_q[0];
	assign tap_conj = s_q[SW-1];
	assign s_idx    = s_q;
	assign pos      = pos_q;

endmodule

// ===== hdl/hssc_mac.sv =====
module hssc_mac import hssc_pkg::*; #(
	parameter int KW = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hssc_term_ctl_t          ctl,
	input  logic [KW-1:0]           k,
	input  logic [WORD_W-1:0]       a,
	input  logic                    a_conj,
	input  logic [WORD_W-1:0]       b,
	input  logic                    b_conj,
	output logic                    result_valid,
	output logic [MODE_W-1:0]       mode_index,
	output logic signed [SUM_W-1:0] sum_re,
	output logic signed [SUM_W-1:0] sum_im,
	output logic                    last_mode,
	output logic                    pipe_busy
);

	logic signed [COEF_W-1:0] ar, ai, br, bi;

	hssc_term_ctl_t           ctl_s1, ctl_s2;
	logic [KW-1:0]            k_s1, k_s2;
	logic                     ca_s1, cb_s1;
	logic signed [PROD_W-1:0] p_rr_s1, p_ii_s1, p_rb_s1, p_ib_s1;
	logic signed [TERM_W-1:0] e_rr, e_ii, e_rb, e_ib, x_im, y_im;
	logic signed [TERM_W-1:0] term_re_c, term_im_c;
	logic signed [TERM_W-1:0] term_re_s2, term_im_s2;
	logic signed [SUM_W-1:0]  base_re, base_im, acc_re_c, acc_im_c;
	logic signed [SUM_W-1:0]  acc_re_q, acc_im_q;
	logic                     result_valid_q, last_mode_q;
	logic [MODE_W-1:0]        mode_index_q;
	logic signed [SUM_W-1:0]  sum_re_q, sum_im_q;

	assign ar = a[WORD_W-1:COEF_W];
	assign ai = a[COEF_W-1:0];
	assign br = b[WORD_W-1:COEF_W];
	assign bi = b[COEF_W-1:0];

	// control of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1         <= '0;
			ctl_s2         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			ctl_s1         <= ctl;
			ctl_s2         <= ctl_s1;
			result_valid_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// stage 1: four partial products, conjugation kept as flags
	always_ff @(posedge clk) begin
		k_s1    <= k;
		ca_s1   <= a_conj;
		cb_s1   <= b_conj;
		p_rr_s1 <= PROD_W'(ar) * PROD_W'(br);
		p_ii_s1 <= PROD_W'(ai) * PROD_W'(bi);
		p_rb_s1 <= PROD_W'(ar) * PROD_W'(bi);
		p_ib_s1 <= PROD_W'(ai) * PROD_W'(br);
	end

	// stage 2: complex product with signs applied
	always_comb begin
		e_rr      = TERM_W'(p_rr_s1);
		e_ii      = TERM_W'(p_ii_s1);
		e_rb      = TERM_W'(p_rb_s1);
		e_ib      = TERM_W'(p_ib_s1);
		term_re_c = (ca_s1 ^ cb_s1) ? e_rr + e_ii : e_rr - e_ii;
		x_im      = cb_s1 ? -e_rb : e_rb;
		y_im      = ca_s1 ? -e_ib : e_ib;
		term_im_c = x_im + y_im;
	end

	always_ff @(posedge clk) begin
		k_s2       <= k_s1;
		term_re_s2 <= term_re_c;
		term_im_s2 <= term_im_c;
	end

	// stage 3: accumulate, restart on the first term of a mode
	always_comb begin
		base_re  = ctl_s2.first ? '0 : acc_re_q;
		base_im  = ctl_s2.first ? '0 : acc_im_q;
		acc_re_c = base_re + SUM_W'(term_re_s2);
		acc_im_c = base_im + SUM_W'(term_im_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_re_q <= acc_re_c;
			acc_im_q <= acc_im_c;
		end
		if (ctl_s2.valid && ctl_s2.last) begin
			mode_index_q <= MODE_W'(k_s2);
			sum_re_q     <= ctl_s2.zero ? '0 : acc_re_c;
			sum_im_q     <= ctl_s2.zero ? '0 : acc_im_c;
			last_mode_q  <= ctl_s2.end_run;
		end
	end

	assign result_valid = result_valid_q;
	assign mode_index   = mode_index_q;
	assign sum_re       = sum_re_q;
	assign sum_im       = sum_im_q;
	assign last_mode    = last_mode_q;
	assign pipe_busy    = ctl_s1.valid || ctl_s2.valid;

endmodule

// ===== hdl/hermitian_spectral_self_convolution.sv =====
// Loads n = mode_count (clamped to 2..MAX_MODES) Q1.15 coefficients, one per
// cycle while busy is low, and on the last of them computes the Hermitian
// self-convolution of every mode k = 0..n-1. The coefficients sit in two
// rings of cells that rotate one place per cycle under a tap; one complex
// multiply-accumulate consumes one term per cycle. After the last load the
// rings rotate into place and seed their indexes. Then (3n^2-n)/2 terms
// follow (2n-1-k terms for mode k). Each result is strobed on result_valid for
// one cycle, after its last term has passed the product, complex-sum and
// accumulate stages, in increasing k with last_mode on k = n-1. The receiver
// cannot stall results. The rings then rotate back to rest and the last result
// leaves the pipeline, after which busy falls.
module hermitian_spectral_self_convolution import hssc_pkg::*; #(
	parameter int MAX_MODES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     start,
	input  logic signed [COEF_W-1:0] coef_re,
	input  logic signed [COEF_W-1:0] coef_im,
	output logic                     busy,
	output logic                     result_valid,
	output logic [MODE_W-1:0]        mode_index,
	output logic signed [SUM_W-1:0]  sum_re,
	output logic signed [SUM_W-1:0]  sum_im,
	output logic                     last_mode
);

	localparam int IW  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
	localparam int NW  = $clog2(MAX_MODES + 1);
	localparam int SW  = IW + 1;
	localparam int AW  = SW + 1;
	localparam int CW  = (NW > CFG_W) ? NW : CFG_W;
	localparam int CKW = (IW > CUT_W) ? IW : CUT_W;

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SEEK   = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_RETURN = 2'd3;

	logic [CFG_W-1:0]     mode_count_q;
	logic [CUT_W-1:0]     cutoff_q;
	logic [1:0]           state_q;
	logic [IW-1:0]        load_count_q;
	logic [NW-1:0]        n_q;
	logic [IW-1:0]        k_q;
	logic                 fwd_q;
	logic                 first_q;

	logic [NW-1:0]        n_eff;
	logic                 accept;
	logic                 batch_end;
	logic [IW-1:0]        n_m1;
	logic signed [SW-1:0] n_m1_s;
	logic                 at_top;
	logic                 last_term;
	logic                 k_end;

	hssc_chain_cmd_t      cmd_a, cmd_b;
	hssc_term_ctl_t       ctl;
	logic [WORD_W-1:0]    wr_data;
	logic [WORD_W-1:0]    tap_a, tap_b;
	logic                 conj_a, conj_b;
	logic signed [SW-1:0] s_a, s_b;
	logic [IW-1:0]        pos_a, pos_b;
	logic                 pipe_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_count_q <= MODE_COUNT_RST;
			cutoff_q     <= CUTOFF_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE_COUNT:  mode_count_q <= cfg_data;
				REG_CUTOFF_MODE: cutoff_q     <= cfg_data[CUT_W-1:0];
			endcase
		end
	end

	// batch length clamped to the supported range
	always_comb begin
		if (CW'(mode_count_q) < CW'(2)) begin
			n_eff = NW'(2);
		end else if (CW'(mode_count_q) > CW'(MAX_MODES)) begin
			n_eff = NW'(MAX_MODES);
		end else begin
			n_eff = NW'(mode_count_q);
		end
	end

	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && (state_q == ST_LOAD);
	assign batch_end = accept && ((NW'(load_count_q) + NW'(1)) >= n_eff);
	assign n_m1      = IW'(n_q - NW'(1));
	assign n_m1_s    = SW'(n_m1);
	assign at_top    = (pos_a == n_m1);
	assign last_term = ((fwd_q ? s_a : s_b) == n_m1_s);
	assign k_end     = (k_q == n_m1);
	assign wr_data   = {coef_re, coef_im};

	// sequencer commands: the ascending operand ends each mode at n-1
	always_comb begin
		cmd_a = '0;
		cmd_b = '0;
		ctl   = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd_a.wr = accept;
				cmd_b.wr = accept;
			end
			ST_SEEK: begin
				cmd_a.seek_up = !at_top;
				cmd_b.seek_up = !at_top;
				cmd_a.init    = at_top;
				cmd_b.init    = at_top;
			end
			ST_RUN: begin
				ctl.valid   = 1'b1;
				ctl.first   = first_q;
				ctl.last    = last_term;
				ctl.zero    = (CKW'(k_q) <= CKW'(cutoff_q));
				ctl.end_run = k_end;
				if (!last_term) begin
					cmd_a.step     = 1'b1;
					cmd_a.step_pos = fwd_q;
					cmd_b.step     = 1'b1;
					cmd_b.step_pos = !fwd_q;
				end else if (!k_end) begin
					// the descending operand moves to the next mode's end point
					if (fwd_q) begin
						cmd_b.step     = 1'b1;
						cmd_b.step_pos = 1'b1;
					end else begin
						cmd_a.step     = 1'b1;
						cmd_a.step_pos = 1'b1;
					end
				end
			end
			ST_RETURN: begin
				cmd_a.seek_down = (pos_a != '0);
				cmd_b.seek_down = (pos_b != '0);
			end
			default: begin
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			n_q          <= NW'(2);
			k_q          <= '0;
			fwd_q        <= 1'b1;
			first_q      <= 1'b1;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (batch_end) begin
						load_count_q <= '0;
						n_q          <= n_eff;
						state_q      <= ST_SEEK;
					end else if (accept) begin
						load_count_q <= load_count_q + 1'b1;
					end
				end
				ST_SEEK: begin
					if (at_top) begin
						k_q     <= '0;
						fwd_q   <= 1'b1;
						first_q <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					first_q <= last_term;
					if (last_term) begin
						if (k_end) begin
							state_q <= ST_RETURN;
						end else begin
							k_q   <= k_q + 1'b1;
							fwd_q <= !fwd_q;
						end
					end
				end
				ST_RETURN: begin
					if ((pos_a == '0) && (pos_b == '0) && !pipe_busy) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	hssc_chain #(.MAX_MODES(MAX_MODES)) u_chain_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_a),
		.wr_idx   (load_count_q),
		.wr_data  (wr_data),
		.init_s   (-n_m1_s),
		.tap      (tap_a),
		.tap_conj (conj_a),
		.s_idx    (s_a),
		.pos      (pos_a)
	);

	hssc_chain #(.MAX_MODES(MAX_MODES)) u_chain_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_b),
		.wr_idx   (load_count_q),
		.wr_data  (wr_data),
		.init_s   (n_m1_s),
		.tap      (tap_b),
		.tap_conj (conj_b),
		.s_idx    (s_b),
		.pos      (pos_b)
	);

	hssc_mac #(.KW(IW)) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.k            (k_q),
		.a            (tap_a),
		.a_conj       (conj_a),
		.b            (tap_b),
		.b_conj       (conj_b),
		.result_valid (result_valid),
		.mode_index   (mode_index),
		.sum_re       (sum_re),
		.sum_im       (sum_im),
		.last_mode    (last_mode),
		.pipe_busy    (pipe_busy)
	);

	// loads always find both rings at rest
	a_load_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ((pos_a == '0) && (pos_b == '0)))
		else $error("coefficient ring not at rest while loading");

	// the two operands always pair up to the current mode
	a_pair_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((AW'(s_a) + AW'(s_b)) == AW'(k_q)))
		else $error("operand indexes do not sum to the mode");

	// no result strobe once the block is taking coefficients again
	a_no_late_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q != ST_LOAD))
		else $error("result strobe after the batch was closed");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import hssc_pkg::*;

	localparam int MAX_MODES     = 64;
	localparam int IDX_W         = $clog2(MAX_MODES);
	localparam int RANDOM_ITEMS  = 270;
	localparam int SETTLE_CYCLES = 2 * MAX_MODES + 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic signed [COEF_W-1:0] re;
		logic signed [COEF_W-1:0] im;
	} coef_item_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [SUM_W-1:0]  re;
		logic [SUM_W-1:0]  im;
		logic              last;
	} mode_sum_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = REG_MODE_COUNT;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     start = 1'b0;
	logic signed [COEF_W-1:0] coef_re = '0;
	logic signed [COEF_W-1:0] coef_im = '0;
	logic                     busy;
	logic                     result_valid;
	logic [MODE_W-1:0]        mode_index;
	logic signed [SUM_W-1:0]  sum_re;
	logic signed [SUM_W-1:0]  sum_im;
	logic                     last_mode;

	// requests waiting to be offered, and mode sums still owed by the block
	coef_item_t pending_coefs[$];
	mode_sum_t  expected_sums[$];

	// shadow of the block: register copies, coefficient store, load position
	logic [CFG_W-1:0] mode_reg = MODE_COUNT_RST;
	logic [CUT_W-1:0] cut_reg  = CUTOFF_MODE_RST;
	coef_item_t       spectrum[MAX_MODES];
	int               loaded = 0;

	int  gap_left = 0;
	bit  gaps_on = 1'b1;
	int  fail_count = 0;
	int  coefs_taken = 0;
	int  batches_done = 0;
	int  results_seen = 0;
	int  cycle_count = 0;

	hermitian_spectral_self_convolution #(
		.MAX_MODES(MAX_MODES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.coef_re     (coef_re),
		.coef_im     (coef_im),
		.busy        (busy),
		.result_valid(result_valid),
		.mode_index  (mode_index),
		.sum_re      (sum_re),
		.sum_im      (sum_im),
		.last_mode   (last_mode)
	);

	always #5 clk = ~clk;

	// batch length after clamping to the supported range
	function automatic int clamp_modes(input logic [CFG_W-1:0] val);
		int n;
		n = int'(val);
		if (n < 2) n = 2;
		if (n > MAX_MODES) n = MAX_MODES;
		return n;
	endfunction

	// coefficient at signed wavenumber m, negative side as the conjugate
	function automatic void coef_at(input int m, output longint re, output longint im);
		coef_item_t c;
		c = spectrum[IDX_W'(m < 0 ? -m : m)];
		re = longint'(c.re);
		im = longint'(c.im);
		if (m < 0) im = -im;
	endfunction

	// store one coefficient; on the last of a batch queue every mode sum
	function automatic void take_coefficient(input coef_item_t c);
		int        n;
		longint    acc_re, acc_im, ar, ai, br, bi;
		mode_sum_t s;
		n = clamp_modes(mode_reg);
		if (loaded < MAX_MODES) spectrum[IDX_W'(loaded)] = c;
		if (loaded + 1 < n) begin
			loaded++;
			return;
		end
		loaded = 0;
		batches_done++;
		for (int k = 0; k < n; k++) begin
			acc_re = 0;
			acc_im = 0;
			// forcing band stays at zero
			if (k > int'(cut_reg)) begin
				for (int j = k + 1 - n; j < n; j++) begin
					coef_at(j, ar, ai);
					coef_at(k - j, br, bi);
					acc_re += ar * br - ai * bi;
					acc_im += ar * bi + ai * br;
				end
			end
			s.mode = k[MODE_W-1:0];
			s.re   = acc_re[SUM_W-1:0];
			s.im   = acc_im[SUM_W-1:0];
			s.last = (k == n - 1);
			expected_sums.push_back(s);
		end
	endfunction

	// mostly back to back, some short pauses, the odd long one
	function automatic int draw_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// request driver: offers queued coefficients, holding each until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			coef_re <= '0;
			coef_im <= '0;
		end else begin
			if (start && !busy) begin
				take_coefficient('{re: coef_re, im: coef_im});
				coefs_taken++;
				gap_left = draw_gap();
			end
			if (start && busy) begin
				// still waiting for the block
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_coefs.size() != 0) begin
				coef_item_t c;
				c = pending_coefs.pop_front();
				start   <= 1'b1;
				coef_re <= c.re;
				coef_im <= c.im;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor: each strobe against the oldest owed mode sum
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_seen++;
			if (expected_sums.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: mode %0d re %0d im %0d last %0b",
						mode_index, sum_re, sum_im, last_mode);
			end else begin
				mode_sum_t e;
				e = expected_sums.pop_front();
				if (mode_index !== e.mode || sum_re !== e.re || sum_im !== e.im ||
						last_mode !== e.last) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: exp mode %0d re %0d im %0d last %0b,",
							e.mode, $signed(e.re), $signed(e.im), e.last,
							" got mode %0d re %0d im %0d last %0b",
							mode_index, sum_re, sum_im, last_mode);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums still owed",
				cycle_count, expected_sums.size());
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE_COUNT) mode_reg = val;
		else cut_reg = val[CUT_W-1:0];
	endtask

	task automatic push_coef(input logic [COEF_W-1:0] re, input logic [COEF_W-1:0] im);
		pending_coefs.push_back('{re: re, im: im});
	endtask

	// wait until all requests are taken and every sum has come back
	task automatic settle();
		while (pending_coefs.size() != 0 || start || expected_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [COEF_W-1:0] pick_part();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return {1'b1, {(COEF_W-1){1'b0}}};
		if (r < 16) return {1'b0, {(COEF_W-1){1'b1}}};
		if (r < 20) return '0;
		if (r < 24) return '1;
		return COEF_W'($urandom);
	endfunction

	// mostly short batches, a few long ones, now and then a clamped value
	function automatic logic [CFG_W-1:0] pick_mode_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return CFG_W'($urandom_range(2, 12));
		if (r < 88) return CFG_W'($urandom_range(13, 40));
		if (r < 94) return CFG_W'(MAX_MODES);
		if (r < 97) return CFG_W'($urandom_range(0, 1));
		return CFG_W'($urandom_range(MAX_MODES + 1, 127));
	endfunction

	function automatic logic [CFG_W-1:0] pick_cutoff(input int n);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return '0;
		if (r < 85) return CFG_W'($urandom_range(0, n));
		if (r < 95) return CFG_W'($urandom_range(0, 63));
		return 7'd63;
	endfunction

	initial begin
		logic [CFG_W-1:0] mode_val;
		int               n_eff;
		int               cnt;
		int               random_items;
		int               phase;
		random_items = 0;
		phase = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// shortest batch, field extremes
		write_reg(REG_MODE_COUNT, 7'd2);
		write_reg(REG_CUTOFF_MODE, 7'd0);
		push_coef(16'h7FFF, 16'h7FFF);
		push_coef(16'h8000, 16'h8000);
		push_coef(16'h8000, 16'h7FFF);
		push_coef(16'h7FFF, 16'h8000);
		push_coef(16'h0000, 16'hFFFF);
		push_coef(16'hFFFF, 16'h0000);
		settle();

		// count below range clamps to two
		write_reg(REG_MODE_COUNT, 7'd0);
		push_coef(16'h0001, 16'h8000);
		push_coef(16'h8000, 16'h0001);
		settle();

		// cutoff above the batch length zeroes every mode
		write_reg(REG_MODE_COUNT, 7'd4);
		write_reg(REG_CUTOFF_MODE, 7'd63);
		repeat (4) pending_coefs.push_back('{re: pick_part(), im: pick_part()});
		settle();

		// count changed part way through a load
		write_reg(REG_MODE_COUNT, 7'd8);
		write_reg(REG_CUTOFF_MODE, 7'd0);
		repeat (3) pending_coefs.push_back('{re: pick_part(), im: pick_part()});
		settle();
		write_reg(REG_MODE_COUNT, 7'd4);
		write_reg(REG_CUTOFF_MODE, 7'd1);
		pending_coefs.push_back('{re: pick_part(), im: pick_part()});
		settle();

		// partial forcing band
		write_reg(REG_MODE_COUNT, 7'd3);
		repeat (3) pending_coefs.push_back('{re: pick_part(), im: pick_part()});
		settle();

		// random phases; the first two take the longest batch
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 0) mode_val = 7'd127;
			else if (phase == 1) mode_val = CFG_W'(MAX_MODES);
			else mode_val = pick_mode_count();
			n_eff = clamp_modes(mode_val);
			write_reg(REG_MODE_COUNT, mode_val);
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_CUTOFF_MODE, pick_cutoff(n_eff));
			if (phase > 1 && $urandom_range(0, 9) == 0)
				cnt = $urandom_range(1, n_eff - 1);
			else
				cnt = n_eff * ((n_eff > 32) ? 1 : $urandom_range(1, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (cnt) pending_coefs.push_back('{re: pick_part(), im: pick_part()});
			random_items += cnt;
			settle();
			phase++;
		end

		$display("%0d coefficients loaded over %0d batches, %0d mode sums checked",
			coefs_taken, batches_done, results_seen);
		$display("%0d random phases across batch lengths 2..%0d, %0d mismatches",
			phase, MAX_MODES, fail_count);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hssc_pkg.sv
hdl/hssc_cell.sv
hdl/hssc_chain.sv
hdl/hssc_mac.sv
hdl/hermitian_spectral_self_convolution.sv
test/tb_top.sv
